// ===== design/nrle_pkg.sv =====
package nrle_pkg;

    localparam int ACTIVE_PIXELS = 181;
    localparam int GRID_COLS     = 15;
    localparam int GRID_ROWS     = 13;

    localparam logic [3:0] RUN_ESCAPE  = 4'hf;
    localparam logic [4:0] RUN_BIAS    = 5'd3;
    localparam logic [3:0] FIRST_COL   = 4'h3;
    localparam logic [7:0] FRAME_LAST  = 8'(ACTIVE_PIXELS);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LITERAL,
        OP_ESCAPE,
        OP_RUN_START,
        OP_ERROR,
        OP_RUN_PIXEL
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic pending;
        logic escape;
        logic overflow;
        logic run_last;
        logic slot_free;
    } status_t;

    function automatic logic [3:0] row_first(input logic [3:0] row);
        logic [3:0] col;
        case (row)
            4'd0:       col = 4'h3;
            4'd1:       col = 4'h2;
            4'd2, 4'd3: col = 4'h1;
            default:    col = 4'h0;
        endcase
        return col;
    endfunction

    function automatic logic [3:0] row_last(input logic [3:0] row);
        logic [3:0] col;
        case (row)
            4'd0:       col = 4'hb;
            4'd1:       col = 4'hc;
            4'd2, 4'd3: col = 4'hd;
            default:    col = 4'he;
        endcase
        return col;
    endfunction

    function automatic logic [7:0] level_lut(input logic [3:0] code);
        logic [7:0] val;
        case (code)
            4'd0:    val = 8'd0;
            4'd1:    val = 8'd18;
            4'd2:    val = 8'd36;
            4'd3:    val = 8'd55;
            4'd4:    val = 8'd73;
            4'd5:    val = 8'd91;
            4'd6:    val = 8'd109;
            4'd7:    val = 8'd128;
            4'd8:    val = 8'd146;
            4'd9:    val = 8'd164;
            4'd10:   val = 8'd182;
            4'd11:   val = 8'd200;
            4'd12:   val = 8'd219;
            4'd13:   val = 8'd237;
            4'd14:   val = 8'd255;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== design/nrle_ctrl.sv =====
module nrle_ctrl
    import nrle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = status.slot_free;
                if (in_valid && status.slot_free)
                begin
                    if (status.pending)
                    begin
                        if (status.overflow)
                        begin
                            cmd.op = OP_ERROR;
                        end
                        else
                        begin
                            cmd.op     = OP_RUN_START;
                            state_next = ST_RUN;
                        end
                    end
                    else if (status.escape)
                    begin
                        cmd.op = OP_ESCAPE;
                    end
                    else
                    begin
                        cmd.op = OP_LITERAL;
                    end
                end
            end
            ST_RUN:
            begin
                if (status.slot_free)
                begin
                    cmd.op = OP_RUN_PIXEL;
                    if (status.run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/nrle_dp.sv =====
module nrle_dp
    import nrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] nibble,
    input  logic       restart,
    input  cmd_t       cmd,
    output status_t    status,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] pixel_index,
    output logic [7:0] pixel_value,
    output logic       frame_done,
    output logic       last_of_run
);

    logic [7:0] count_reg, count_next;
    logic       pending_reg, pending_next;
    logic [3:0] row_reg, row_next;
    logic [3:0] col_reg, col_next;
    logic [4:0] rem_reg, rem_next;

    logic       out_valid_reg, out_valid_next;
    logic       kind_reg, kind_next;
    logic [7:0] index_reg, index_next;
    logic [7:0] value_reg, value_next;
    logic       done_reg, done_next;
    logic       last_reg, last_next;

    // position used for this cycle; restart only applies to an accepted code
    logic       use_clear;
    logic [7:0] base_count;
    logic [3:0] base_row;
    logic [3:0] base_col;

    logic [7:0] pix_index;
    logic [7:0] count_inc;
    logic       pix_done;
    logic [3:0] adv_row;
    logic [3:0] adv_col;
    logic [8:0] run_end;

    assign use_clear  = restart && (cmd.op != OP_RUN_PIXEL);
    assign base_count = use_clear ? 8'd0 : count_reg;
    assign base_row   = use_clear ? 4'd0 : row_reg;
    assign base_col   = use_clear ? FIRST_COL : col_reg;

    // row * 15 + col
    assign pix_index = ({base_row, 4'b0000} - {4'b0000, base_row}) + {4'b0000, base_col};
    assign count_inc = base_count + 8'd1;
    assign pix_done  = (count_inc >= FRAME_LAST);

    always_comb
    begin
        if (base_col >= row_last(base_row))
        begin
            adv_row = base_row + 4'd1;
            adv_col = row_first(base_row + 4'd1);
        end
        else
        begin
            adv_row = base_row;
            adv_col = base_col + 4'd1;
        end
    end

    assign run_end = {1'b0, base_count} + {5'b00000, nibble} + {4'b0000, RUN_BIAS};

    assign status.pending   = restart ? 1'b0 : pending_reg;
    assign status.escape    = (nibble == RUN_ESCAPE);
    assign status.overflow  = (run_end > {1'b0, FRAME_LAST});
    assign status.run_last  = (rem_reg == 5'd1);
    assign status.slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next     = count_reg;
        pending_next   = pending_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        done_next      = done_reg;
        last_next      = last_reg;
        case (cmd.op)
            OP_LITERAL, OP_RUN_PIXEL:
            begin
                out_valid_next = 1'b1;
                kind_next      = 1'b0;
                index_next     = pix_index;
                value_next     = (cmd.op == OP_LITERAL) ? level_lut(nibble) : level_lut(4'd0);
                done_next      = pix_done;
                last_next      = (cmd.op == OP_LITERAL) || status.run_last || pix_done;
                pending_next   = 1'b0;
                if (cmd.op == OP_RUN_PIXEL)
                begin
                    rem_next = rem_reg - 5'd1;
                end
                if (pix_done)
                begin
                    count_next = 8'd0;
                    row_next   = 4'd0;
                    col_next   = FIRST_COL;
                end
                else
                begin
                    count_next = count_inc;
                    row_next   = adv_row;
                    col_next   = adv_col;
                end
            end
            OP_ESCAPE:
            begin
                count_next   = base_count;
                row_next     = base_row;
                col_next     = base_col;
                pending_next = 1'b1;
            end
            OP_RUN_START:
            begin
                count_next   = base_count;
                row_next     = base_row;
                col_next     = base_col;
                pending_next = 1'b0;
                rem_next     = {1'b0, nibble} + RUN_BIAS;
            end
            OP_ERROR:
            begin
                count_next     = 8'd0;
                row_next       = 4'd0;
                col_next       = FIRST_COL;
                pending_next   = 1'b0;
                out_valid_next = 1'b1;
                kind_next      = 1'b1;
                index_next     = 8'd0;
                value_next     = 8'd0;
                done_next      = 1'b0;
                last_next      = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 8'd0;
            pending_reg   <= 1'b0;
            row_reg       <= 4'd0;
            col_reg       <= FIRST_COL;
            rem_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        index_reg <= index_next;
        value_reg <= value_next;
        done_reg  <= done_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign pixel_index = index_reg;
    assign pixel_value = value_reg;
    assign frame_done  = done_reg;
    assign last_of_run = last_reg;

`ifndef ASSERT_OFF
    a_count_below_frame: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < FRAME_LAST)
        else $error("pixel count reached frame size without clearing");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> last_reg && !kind_reg)
        else $error("frame end result not marked last");

    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_ERROR |=> count_reg == 8'd0 && !pending_reg && col_reg == FIRST_COL)
        else $error("run overflow left decoder state behind");

    a_run_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_RUN_PIXEL && !status.run_last |-> !pix_done)
        else $error("frame ended inside a run");
`endif

endmodule

// ===== design/nibble_rle_touch_image_decoder.sv =====
// nibble run-length touch image decoder: one 4-bit code per input transfer, restart clears
// the decoder before the code is used. a literal code (0..14) gives one pixel result, put in
// the output register when the code is accepted, code 15 gives nothing and marks the next
// code as a run length, and that code X gives X+3 zero pixels after its acceptance, one per
// cycle unless the output stalls; no new code is taken meanwhile. each pixel passes through
// the single output register. a run that would pass the 181 active cells gives one error
// result instead and clears the decoder; the 181st pixel carries frame_done and clears it
module nibble_rle_touch_image_decoder
    import nrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] nibble,
    input  logic       restart,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] pixel_index,
    output logic [7:0] pixel_value,
    output logic       frame_done,
    output logic       last_of_run
);

    // command from the sequencer, status back from the datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: takes codes and steps through zero runs
    nrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: grid position, pixel count, run counter and output register
    nrle_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .nibble      (nibble),
        .restart     (restart),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .pixel_index (pixel_index),
        .pixel_value (pixel_value),
        .frame_done  (frame_done),
        .last_of_run (last_of_run)
    );

endmodule
